>>> hw/rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and codes for the periodic timer event bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_REQ   = 3'd1;
   localparam logic [2:0] ACT_REL   = 3'd2;
   localparam logic [2:0] ACT_OPEN  = 3'd3;
   localparam logic [2:0] ACT_CLOSE = 3'd4;
   localparam logic [2:0] ACT_READ  = 3'd5;

   localparam logic [1:0] KIND_REQ  = 2'd0;
   localparam logic [1:0] KIND_FIRE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] reload_value;
      logic [15:0] slot_number;
      logic [31:0] seen_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  slot_index;
      logic        success;
      logic [31:0] tick_value;
      logic        tick_changed;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic              accept;
      logic              step;
      logic [SLOT_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic tick_start;
      logic cur_fire;
   } sts_type;

endpackage

>>> hw/rtl/ptb_ctrl.sv
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer: accepts one item at a time and walks the slots on a tick.
// ----------------------------------------------------------------------------
module ptb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptb_pkg::sts_type sts,
   output ptb_pkg::cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                  state_ff;
   logic [ptb_pkg::SLOT_W-1:0] idx_ff;
   logic                       accept;
   logic                       step;

   assign req_stall = !(state_ff == ST_IDLE && sts.out_free);
   assign accept    = req_valid && state_ff == ST_IDLE && sts.out_free;
   assign step      = state_ff == ST_SCAN && (!sts.cur_fire || sts.out_free);

   assign cmd.accept = accept;
   assign cmd.step   = step;
   assign cmd.idx    = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (accept && sts.tick_start) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (step) begin
                  if (idx_ff == ptb_pkg::SLOT_W'(ptb_pkg::SLOT_COUNT - 1)) begin
                     state_ff <= ST_IDLE;
                     idx_ff   <= '0;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hw/rtl/ptb_dp.sv
// ----------------------------------------------------------------------------
// ptb_dp
// Slot stores, tick counter, bank flags and the result register.
// ----------------------------------------------------------------------------
module ptb_dp (
   input  logic             clock,
   input  logic             reset,
   input  ptb_pkg::req_type req_payload,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output ptb_pkg::rsp_type rsp_payload,
   input  ptb_pkg::cmd_type cmd,
   output ptb_pkg::sts_type sts
);

   localparam int N = ptb_pkg::SLOT_COUNT;

   logic [N-1:0]              used_ff, used_in;
   logic [15:0]               cd_ff [N];
   logic [15:0]               cd_in [N];
   logic [15:0]               period_ff [N];
   logic [15:0]               period_in [N];
   logic [N-1:0]              fire_ff, fire_in;
   logic [ptb_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      running_ff, running_in;
   logic                      open_ff, open_in;
   logic [31:0]               total_ff, total_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ptb_pkg::rsp_type          rsp_ff, rsp_in;

   logic                      out_free;
   logic [N-1:0]              fire_mask;
   logic [N-1:0]              base_used;
   logic [ptb_pkg::CNT_W-1:0] base_cnt;
   logic                      found;
   logic [ptb_pkg::SLOT_W-1:0] free_idx;
   logic [ptb_pkg::SLOT_W-1:0] rel_idx;
   logic                      more_fire;
   logic                      load;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rel_idx    = req_payload.slot_number[ptb_pkg::SLOT_W-1:0];

   assign sts.out_free   = out_free;
   assign sts.tick_start = req_payload.action == ptb_pkg::ACT_TICK && running_ff;
   assign sts.cur_fire   = fire_ff[cmd.idx];

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      fire_mask = '0;
      more_fire = 1'b0;
      found     = 1'b0;
      free_idx  = '0;
      for (int i = 0; i < N; i++) begin
         fire_mask[i] = used_ff[i] && cd_ff[i] == 16'd1;
         if (i > int'(cmd.idx) && fire_ff[i]) begin
            more_fire = 1'b1;
         end
      end
      base_used = running_ff ? used_ff : '0;
      base_cnt  = running_ff ? cnt_ff : '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!base_used[i]) begin
            found    = 1'b1;
            free_idx = ptb_pkg::SLOT_W'(i);
         end
      end
   end

   always_comb begin
      used_in    = used_ff;
      cd_in      = cd_ff;
      period_in  = period_ff;
      fire_in    = fire_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      open_in    = open_ff;
      total_in   = total_ff;
      load       = 1'b0;
      rsp_in     = rsp_ff;

      if (cmd.accept) begin
         case (req_payload.action)
            ptb_pkg::ACT_TICK: begin
               if (running_ff) begin
                  total_in   = total_ff + 32'd1;
                  fire_in    = fire_mask;
                  running_in = !(cnt_ff == '0 && !open_ff);
               end
            end
            ptb_pkg::ACT_REQ: begin
               running_in = 1'b1;
               used_in    = base_used;
               cnt_in     = base_cnt;
               if (found) begin
                  used_in[free_idx]   = 1'b1;
                  cd_in[free_idx]     = req_payload.reload_value;
                  period_in[free_idx] = req_payload.reload_value;
                  cnt_in              = base_cnt + 1'b1;
               end
               load   = 1'b1;
               rsp_in = '{result_kind: ptb_pkg::KIND_REQ,
                          slot_index: 3'(free_idx), success: found,
                          tick_value: 32'd0, tick_changed: 1'b0,
                          last_result: 1'b1};
            end
            ptb_pkg::ACT_REL: begin
               if (req_payload.slot_number < 16'(N) && used_ff[rel_idx]) begin
                  used_in[rel_idx] = 1'b0;
                  if (cnt_ff != '0) begin
                     cnt_in = cnt_ff - 1'b1;
                  end
               end
            end
            ptb_pkg::ACT_OPEN: begin
               if (!running_ff) begin
                  used_in    = '0;
                  cnt_in     = '0;
                  running_in = 1'b1;
               end
               if (!open_ff) begin
                  total_in = 32'd0;
               end
               open_in = 1'b1;
            end
            ptb_pkg::ACT_CLOSE: begin
               open_in = 1'b0;
            end
            ptb_pkg::ACT_READ: begin
               load   = 1'b1;
               rsp_in = '{result_kind: ptb_pkg::KIND_READ, slot_index: 3'd0,
                          success: 1'b0,
                          tick_value: open_ff ? total_ff : 32'd0,
                          tick_changed: open_ff && total_ff != req_payload.seen_ticks,
                          last_result: 1'b1};
            end
            default: ;
         endcase
      end

      if (cmd.step) begin
         if (used_ff[cmd.idx]) begin
            cd_in[cmd.idx] = fire_ff[cmd.idx] ? period_ff[cmd.idx]
                                              : cd_ff[cmd.idx] - 16'd1;
         end
         if (fire_ff[cmd.idx]) begin
            load   = 1'b1;
            rsp_in = '{result_kind: ptb_pkg::KIND_FIRE,
                       slot_index: 3'(cmd.idx), success: 1'b0,
                       tick_value: 32'd0, tick_changed: 1'b0,
                       last_result: !more_fire};
         end
      end

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         fire_ff      <= '0;
         cnt_ff       <= '0;
         running_ff   <= 1'b0;
         open_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         fire_ff      <= fire_in;
         cnt_ff       <= cnt_in;
         running_ff   <= running_in;
         open_ff      <= open_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cd_ff     <= cd_in;
      period_ff <= period_in;
      rsp_ff    <= rsp_in;
   end

endmodule

>>> hw/rtl/periodic_timer_event_bank_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_event_bank_top
// Bank of eight periodic event slots with a 32-bit tick counter.
// ----------------------------------------------------------------------------
// Input channel req_valid/req_stall/req_payload carries one action per
// transfer: tick, request, release, open tick, close tick or read tick.
// Result channel rsp_valid/rsp_stall/rsp_payload carries request answers,
// fired-slot reports and tick read answers; last_result marks the final
// result of an action.
// Request, release, open, close and read end with their transfer; a request
// or read answer is presented in the cycle after its transfer.
// A tick on a running bank walks the slots, one per cycle unless a firing
// slot waits on a stalled receiver; it holds the block until the walk ends,
// and each firing slot's report leaves as the walk reaches it.
// A single output register holds a pending result; while the receiver
// stalls, a walk pauses on the next firing slot and no new action is taken.
// Synchronous reset clears the slot use flags, counters, running and open
// flags and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_timer_event_bank_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptb_pkg::rsp_type rsp_payload
);

   ptb_pkg::cmd_type cmd;
   ptb_pkg::sts_type sts;

   ptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptb_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
